/* src/utf8d_pkg.sv */
`default_nettype none

package utf8d_pkg;

  // Longest sequence the decoder accepts (4 to 6)
  localparam int MAX_SEQUENCE_BYTES = 6;

  // One lane per byte that can follow the lead byte in the window
  localparam int NUM_LANES = 5;

  localparam logic [7:0] CONT_MASK   = 8'hC0;
  localparam logic [7:0] CONT_MARK   = 8'h80;
  localparam logic [7:0] LEAD_MIN    = 8'hC0;

  typedef struct packed {
    logic [7:0] lead_byte;
    logic [7:0] next_byte_1;
    logic [7:0] next_byte_2;
    logic [7:0] next_byte_3;
    logic [7:0] next_byte_4;
    logic [7:0] next_byte_5;
    logic [2:0] bytes_available;
  } item_t;

  typedef struct packed {
    logic [30:0] codepoint;
    logic [2:0]  sequence_length;
  } result_t;

  // What one lane reports on its byte
  typedef struct packed {
    logic       cont_ok;
    logic [5:0] bits;
  } lane_t;

endpackage

`default_nettype wire

/* src/utf8d_lane.sv */
`default_nettype none

module utf8d_lane (
  input  wire logic [7:0]     byte_in,
  output utf8d_pkg::lane_t    lane
);
  import utf8d_pkg::*;

  // continuation byte is 10xxxxxx; carries six payload bits
  always_comb begin
    lane.cont_ok = ((byte_in & CONT_MASK) == CONT_MARK);
    lane.bits    = byte_in[5:0];
  end

endmodule

`default_nettype wire

/* src/utf8d_merge.sv */
`default_nettype none

module utf8d_merge (
  input  wire logic [7:0]       lead_byte,
  input  wire logic [2:0]       bytes_available,
  input  wire utf8d_pkg::lane_t lanes [utf8d_pkg::NUM_LANES],
  output utf8d_pkg::result_t    result
);
  import utf8d_pkg::*;

  logic [2:0]  len;
  logic        len_ok;
  logic        cont_ok;
  logic        avail_ok;
  logic [30:0] value;

  // sequence length from the lead byte's run of leading ones
  always_comb begin
    len_ok = 1'b1;
    case (lead_byte) inside
      [8'hC0:8'hDF]: len = 3'd2;
      [8'hE0:8'hEF]: len = 3'd3;
      [8'hF0:8'hF7]: len = 3'd4;
      [8'hF8:8'hFB]: len = 3'd5;
      [8'hFC:8'hFD]: len = 3'd6;
      default: begin
        len    = 3'd1;
        len_ok = 1'b0;
      end
    endcase
    if (len > 3'(MAX_SEQUENCE_BYTES)) begin
      len_ok = 1'b0;
    end
  end

  // every byte the sequence needs must be a continuation byte
  always_comb begin
    cont_ok = 1'b1;
    for (int i = 0; i < NUM_LANES; i++) begin
      if ((3'(i + 1) < len) && !lanes[i].cont_ok) begin
        cont_ok = 1'b0;
      end
    end
  end

  assign avail_ok = (len <= bytes_available);

  always_comb begin
    case (len)
      3'd2: value = 31'({lead_byte[4:0], lanes[0].bits});
      3'd3: value = 31'({lead_byte[3:0], lanes[0].bits, lanes[1].bits});
      3'd4: value = 31'({lead_byte[2:0], lanes[0].bits, lanes[1].bits,
                         lanes[2].bits});
      3'd5: value = 31'({lead_byte[1:0], lanes[0].bits, lanes[1].bits,
                         lanes[2].bits, lanes[3].bits});
      3'd6: value = {lead_byte[0], lanes[0].bits, lanes[1].bits,
                     lanes[2].bits, lanes[3].bits, lanes[4].bits};
      default: value = 31'(lead_byte);
    endcase
  end

  // anything that fails falls back to the lead byte as Latin-1
  always_comb begin
    if ((lead_byte >= LEAD_MIN) && len_ok && avail_ok && cont_ok) begin
      result.codepoint       = value;
      result.sequence_length = len;
    end else begin
      result.codepoint       = 31'(lead_byte);
      result.sequence_length = 3'd1;
    end
  end

endmodule

`default_nettype wire

/* src/utf8_sequence_decoder.sv */
// UTF-8 sequence decoder, six-byte window with Latin-1 fallback.
// Request channel (item_valid / item_ready / item): one window of six bytes
// starting at a sequence position, plus the count of bytes present (0..7).
// Result channel (result_valid / result_ready / result): the codepoint and
// the number of bytes consumed; the caller advances by sequence_length.
// One result per request, in request order.
// Each request passes one register after the byte lanes and one after the
// merge, which holds the result on the output.
// Throughput: one request per cycle unless stalled; all five continuation
// lanes and the merge work on a window at once, so nothing iterates.
// When the receiver stalls, a skid register takes one more result, so the
// request side can take one more request before item_ready drops; item_ready
// drops on a registered condition only.
// Reset (rst, synchronous) empties the lane stage, output and skid registers.
`default_nettype none

module utf8_sequence_decoder (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire utf8d_pkg::item_t   item,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output utf8d_pkg::result_t      result
);
  import utf8d_pkg::*;

  logic [7:0] lane_byte [NUM_LANES];
  lane_t      lane_res  [NUM_LANES];

  // lane stage
  logic       s1_valid;
  logic [7:0] s1_lead;
  logic [2:0] s1_avail;
  lane_t      s1_lanes  [NUM_LANES];

  result_t    merged;

  logic       sk_valid;
  result_t    sk_data;
  logic       push;

  assign lane_byte[0] = item.next_byte_1;
  assign lane_byte[1] = item.next_byte_2;
  assign lane_byte[2] = item.next_byte_3;
  assign lane_byte[3] = item.next_byte_4;
  assign lane_byte[4] = item.next_byte_5;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    utf8d_lane u_lane (
      .byte_in (lane_byte[g]),
      .lane    (lane_res[g])
    );
  end

  assign push       = s1_valid && !sk_valid;
  assign item_ready = !s1_valid || !sk_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1_lead  <= item.lead_byte;
      s1_avail <= item.bytes_available;
      s1_lanes <= lane_res;
    end
  end

  utf8d_merge u_merge (
    .lead_byte       (s1_lead),
    .bytes_available (s1_avail),
    .lanes           (s1_lanes),
    .result          (merged)
  );

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      sk_valid     <= 1'b0;
    end else if (!result_valid || result_ready) begin
      if (sk_valid) begin
        result_valid <= 1'b1;
        sk_valid     <= 1'b0;
      end else begin
        result_valid <= push;
      end
    end else if (push) begin
      sk_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || result_ready) begin
      result <= sk_valid ? sk_data : merged;
    end else if (push) begin
      sk_data <= merged;
    end
  end

  // skid only fills behind a stalled output
  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    sk_valid |-> result_valid)
    else $error("skid register holds a request with the output empty");

  a_fallback_is_byte: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.sequence_length == 3'd1) |->
      (result.codepoint[30:8] == 23'd0))
    else $error("single-byte result wider than a byte");

  a_length_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.sequence_length >= 3'd1 &&
                      result.sequence_length <= 3'(MAX_SEQUENCE_BYTES)))
    else $error("sequence length out of range");

  a_stall_keeps_skid: assert property (@(posedge clk) disable iff (rst)
    (sk_valid && !result_ready) |=> sk_valid)
    else $error("skid request dropped while output stalled");

endmodule

`default_nettype wire

/* tb/sv/utf8_sequence_decoder_test.sv */
`timescale 1ns / 100ps

module utf8_sequence_decoder_test;
  import utf8d_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int GAP_PERCENT = 28;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  item_t   pending_windows[$];
  result_t expected_decodes[$];
  bit      gaps_on = 1'b1;
  int      mismatches = 0;
  int      cycle_count = 0;

  utf8_sequence_decoder i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Leading ones of the lead byte give the length; anything that does not
  // form a complete sequence falls back to the lead byte as Latin-1.
  function automatic result_t decode_window(input item_t w);
    logic [7:0]  win [0:5];
    logic [7:0]  probe;
    logic [30:0] value;
    int          len;
    result_t     r;
    win[0] = w.lead_byte;
    win[1] = w.next_byte_1;
    win[2] = w.next_byte_2;
    win[3] = w.next_byte_3;
    win[4] = w.next_byte_4;
    win[5] = w.next_byte_5;
    r.codepoint       = {23'd0, w.lead_byte};
    r.sequence_length = 3'd1;
    if (w.lead_byte < LEAD_MIN) return r;
    len   = 2;
    probe = 8'h20;
    while (probe != 8'd0 && (w.lead_byte & probe) != 8'd0) begin
      len++;
      probe = probe >> 1;
    end
    if (len > MAX_SEQUENCE_BYTES || len > int'(w.bytes_available)) return r;
    value = (probe == 8'd0) ? 31'd0 : 31'(w.lead_byte & (probe - 8'd1));
    for (int k = 1; k < len; k++) begin
      if ((win[k] & CONT_MASK) != CONT_MARK) return r;
      value = {value[24:0], win[k][5:0]};
    end
    r.codepoint       = value;
    r.sequence_length = 3'(len);
    return r;
  endfunction

  function automatic item_t window(input logic [7:0] b0, b1, b2, b3, b4, b5,
                                   input logic [2:0] avail);
    item_t w;
    w.lead_byte       = b0;
    w.next_byte_1     = b1;
    w.next_byte_2     = b2;
    w.next_byte_3     = b3;
    w.next_byte_4     = b4;
    w.next_byte_5     = b5;
    w.bytes_available = avail;
    return w;
  endfunction

  // Mostly well-formed sequences with random payload, some with one broken
  // continuation byte or a short window, the rest long leads and noise.
  function automatic item_t random_window();
    logic [7:0] win [0:5];
    logic [7:0] bad_tops [0:2] = '{8'h00, 8'h40, 8'hC0};
    logic [2:0] avail;
    int         kind, len, spot;
    kind = $urandom_range(99);
    for (int k = 0; k < 6; k++) win[k] = 8'($urandom);
    avail = 3'($urandom);
    if (kind < 88) begin
      len = $urandom_range(1, MAX_SEQUENCE_BYTES);
      if (len == 1) begin
        win[0] = 8'($urandom_range(8'hBF));
      end else begin
        win[0] = ~(8'hFF >> len) | (win[0] & (8'h7F >> len));
        for (int k = 1; k < len; k++) win[k] = CONT_MARK | (win[k] & ~CONT_MASK);
        if (kind >= 75) begin
          spot = $urandom_range(1, len - 1);
          win[spot] = bad_tops[$urandom_range(2)] | (win[spot] & ~CONT_MASK);
        end
      end
      if (len > 1 && $urandom_range(9) == 0)
        avail = 3'($urandom_range(0, len - 1));
      else
        avail = 3'($urandom_range(len, 7));
    end else if (kind < 94) begin
      win[0] = 8'($urandom_range(8'hF8, 8'hFF));
    end
    return window(win[0], win[1], win[2], win[3], win[4], win[5], avail);
  endfunction

  // driver: next request goes out once the current one is taken
  always @(posedge clk) begin : driver
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) expected_decodes.push_back(decode_window(item));
      if (!item_valid || item_ready) begin
        if (pending_windows.size() != 0 &&
            !(gaps_on && $urandom_range(99) < GAP_PERCENT)) begin
          item       <= pending_windows.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_decodes.size() == 0) begin
          $error("unexpected result: codepoint %h, sequence_length %0d",
                 result.codepoint, result.sequence_length);
          mismatches++;
        end else begin
          want = expected_decodes.pop_front();
          if (result.codepoint !== want.codepoint) begin
            $error("codepoint: expected %h, got %h", want.codepoint, result.codepoint);
            mismatches++;
          end
          if (result.sequence_length !== want.sequence_length) begin
            $error("sequence_length: expected %0d, got %0d",
                   want.sequence_length, result.sequence_length);
            mismatches++;
          end
        end
      end
      result_ready <= !(gaps_on && $urandom_range(99) < GAP_PERCENT);
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic drain();
    do @(negedge clk);
    while (pending_windows.size() != 0 || item_valid || expected_decodes.size() != 0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ASCII and stray continuations pass through whatever the window says
    pending_windows.push_back(window(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd0));
    pending_windows.push_back(window(8'h7F, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd1));
    pending_windows.push_back(window(8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd6));
    pending_windows.push_back(window(8'hBF, 8'hBF, 8'h00, 8'h00, 8'h00, 8'h00, 3'd3));
    // well-formed, every length, overlong forms and a surrogate
    pending_windows.push_back(window(8'hC2, 8'hA9, 8'h00, 8'h00, 8'h00, 8'h00, 3'd2));
    pending_windows.push_back(window(8'hDF, 8'hBF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7));
    pending_windows.push_back(window(8'hC0, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 3'd2));
    pending_windows.push_back(window(8'hE2, 8'h82, 8'hAC, 8'h00, 8'h00, 8'h00, 3'd3));
    pending_windows.push_back(window(8'hED, 8'hA0, 8'h80, 8'h00, 8'h00, 8'h00, 3'd3));
    pending_windows.push_back(window(8'hF0, 8'h9F, 8'h98, 8'h80, 8'h00, 8'h00, 3'd4));
    pending_windows.push_back(window(8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h41, 8'h41, 3'd5));
    pending_windows.push_back(window(8'hF8, 8'h88, 8'h80, 8'h80, 8'h80, 8'h00, 3'd5));
    pending_windows.push_back(window(8'hFB, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hFF, 3'd6));
    pending_windows.push_back(window(8'hFC, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd6));
    pending_windows.push_back(window(8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd6));
    pending_windows.push_back(window(8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd7));
    // too long for any window
    pending_windows.push_back(window(8'hFE, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd7));
    pending_windows.push_back(window(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7));
    // truncated, including an empty window
    pending_windows.push_back(window(8'hE2, 8'h82, 8'hAC, 8'h00, 8'h00, 8'h00, 3'd2));
    pending_windows.push_back(window(8'hC2, 8'hA9, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0));
    pending_windows.push_back(window(8'hF0, 8'h9F, 8'h98, 8'h80, 8'h00, 8'h00, 3'd3));
    // bad continuation bytes
    pending_windows.push_back(window(8'hC2, 8'h41, 8'h00, 8'h00, 8'h00, 8'h00, 3'd2));
    pending_windows.push_back(window(8'hC2, 8'hC0, 8'h00, 8'h00, 8'h00, 8'h00, 3'd2));
    pending_windows.push_back(window(8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'h3F, 3'd6));
    drain();

    repeat (350) pending_windows.push_back(random_window());
    // sender holds off here until the pipe is empty
    drain();

    // long stretch at full rate on both sides
    gaps_on = 1'b0;
    repeat (350) pending_windows.push_back(random_window());
    drain();

    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_decodes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* utf8_sequence_decoder.f */
src/utf8d_pkg.sv
src/utf8d_lane.sv
src/utf8d_merge.sv
src/utf8_sequence_decoder.sv
tb/sv/utf8_sequence_decoder_test.sv
